// ===== src/sfr_pkg.sv =====
// Shared types, constants and helpers for the serial frame receiver.
// No dependencies; every module of the block but sfr_checker imports this package.
package sfr_pkg;

  localparam int FRAME_BUFFER_DEPTH = 64;
  localparam int ADDR_W = $clog2(FRAME_BUFFER_DEPTH);
  // Longest frame that fits both the buffer and a 6-bit position.
  localparam int FRAME_CAP = (FRAME_BUFFER_DEPTH < 64) ? FRAME_BUFFER_DEPTH : 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] FIRST_HEADER_RST = 8'hAA;
  localparam logic [7:0] SECOND_HEADER_RST = 8'hAF;
  localparam logic [8:0] FUNCTION_LIMIT_RST = 9'hF1;
  localparam logic [5:0] LENGTH_LIMIT_RST = 6'd50;

  localparam logic [7:0] REG_FIRST_HEADER = 8'd0;
  localparam logic [7:0] REG_SECOND_HEADER = 8'd1;
  localparam logic [7:0] REG_FUNCTION_LIMIT = 8'd2;
  localparam logic [7:0] REG_LENGTH_LIMIT = 8'd3;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR1,
    PH_HDR2,
    PH_FUNC,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef enum logic {
    OP_STORE,
    OP_FLUSH
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [5:0] pos;
    logic [7:0] data;
    logic [6:0] total;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [5:0] pos);
    return ADDR_W'(pos);
  endfunction

endpackage

// ===== src/serial_frame_receiver.sv =====
// Serial frame receiver top level: parser front end, command queue, readout back end.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
// Takes one received byte per transfer on rx_byte and hunts for frames made of two
// header bytes, a function byte below function_limit, a length byte L below
// length_limit, L payload bytes and a trailing byte. Each byte of a frame in
// progress is kept in the frame buffer; when the trailing byte lands, the frame's
// L + 5 bytes come out in order on frame_byte, with their position, the frame
// total and last_byte set on the final one. A byte that breaks the pattern sends
// the parser back to hunting and is dropped; after a length of zero the next byte
// is dropped and the parser hunts again. Input bytes are taken at one per cycle
// while the four-entry command queue has room; for each frame byte the readout
// goes through a memory read state and then an output transfer state, and while it runs
// the queue fills and the input stalls. Configuration writes take effect at once
// (cfg_ready is always high) and belong to idle periods. The frame buffer starts
// undefined and needs no clearing pass: every byte read out was written in the
// same frame.
module serial_frame_receiver import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic [5:0] byte_position,
  output logic [6:0] frame_total,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [8:0] cfg_data
);

  // commands from parser to readout
  logic q_full;
  logic q_push;
  op_t  q_push_op;
  logic q_pop;
  logic q_head_valid;
  op_t  q_head_op;

  // classify bytes and issue store / flush commands
  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_op   (q_push_op)
  );

  // decouple the parser from a readout in progress
  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  // write the buffer in order and replay completed frames
  sfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .op_valid      (q_head_valid),
    .op            (q_head_op),
    .op_pop        (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .frame_total   (frame_total),
    .last_byte     (last_byte)
  );

endmodule

// ===== src/sfr_front.sv =====
// Front end: configuration registers and the frame parser.
// Depends on sfr_pkg; emits store and flush commands toward the queue.
module sfr_front import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       q_full,
  output logic       push,
  output op_t        push_op
);

  logic [7:0] first_header;
  logic [7:0] second_header;
  logic [8:0] function_limit;
  logic [5:0] length_limit;

  phase_t     phase, phase_next;
  logic [5:0] rem, rem_next;
  logic [5:0] cnt, cnt_next;
  logic       len_ok;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header   <= FIRST_HEADER_RST;
      second_header  <= SECOND_HEADER_RST;
      function_limit <= FUNCTION_LIMIT_RST;
      length_limit   <= LENGTH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIRST_HEADER:   first_header   <= cfg_data[7:0];
        REG_SECOND_HEADER:  second_header  <= cfg_data[7:0];
        REG_FUNCTION_LIMIT: function_limit <= cfg_data;
        REG_LENGTH_LIMIT:   length_limit   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      rem   <= '0;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      rem   <= rem_next;
      cnt   <= cnt_next;
    end
  end

  assign len_ok = ({1'b0, rx_byte} < {3'b000, length_limit})
               && (({1'b0, rx_byte} + 9'd5) <= 9'(FRAME_CAP));

  always_comb begin
    phase_next    = phase;
    rem_next      = rem;
    cnt_next      = cnt;
    push          = 1'b0;
    push_op.kind  = OP_STORE;
    push_op.pos   = '0;
    push_op.data  = rx_byte;
    push_op.total = '0;
    if (in_valid && in_ready) begin
      phase_next = PH_HUNT;
      case (phase)
        PH_HUNT: begin
          if (rx_byte == first_header) begin
            phase_next  = PH_HDR1;
            push        = 1'b1;
            push_op.pos = 6'd0;
          end
        end
        PH_HDR1: begin
          if (rx_byte == second_header) begin
            phase_next  = PH_HDR2;
            push        = 1'b1;
            push_op.pos = 6'd1;
          end
        end
        PH_HDR2: begin
          if ({1'b0, rx_byte} < function_limit) begin
            phase_next  = PH_FUNC;
            push        = 1'b1;
            push_op.pos = 6'd2;
          end
        end
        PH_FUNC: begin
          if (len_ok) begin
            phase_next  = PH_PAYLOAD;
            push        = 1'b1;
            push_op.pos = 6'd3;
            rem_next    = rx_byte[5:0];
            cnt_next    = '0;
          end
        end
        PH_PAYLOAD: begin
          // zero length drops back to hunting with the byte discarded
          if (rem != 6'd0) begin
            push        = 1'b1;
            push_op.pos = cnt + 6'd4;
            rem_next    = rem - 6'd1;
            cnt_next    = cnt + 6'd1;
            phase_next  = (rem == 6'd1) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_TRAILER: begin
          push          = 1'b1;
          push_op.kind  = OP_FLUSH;
          push_op.pos   = cnt + 6'd4;
          push_op.total = {1'b0, cnt} + 7'd5;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/sfr_queue.sv =====
// Short command queue between parser and frame readout.
// Depends on sfr_pkg for the command type and depth.
module sfr_queue import sfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/sfr_back.sv =====
// Back end: frame buffer memory, store execution and frame readout.
// Depends on sfr_pkg; consumes commands from sfr_queue.
module sfr_back import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       op_valid,
  input  op_t        op,
  output logic       op_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic [5:0] byte_position,
  output logic [6:0] frame_total,
  output logic       last_byte
);

  logic [7:0]  mem [FRAME_BUFFER_DEPTH];
  logic [7:0]  mem_q;
  logic        mem_we;

  back_state_t state, state_next;
  logic [5:0]  idx, idx_next;
  logic [6:0]  total, total_next;
  logic        last;

  always_ff @(posedge clk) begin
    if (mem_we) mem[to_addr(op.pos)] <= op.data;
    mem_q <= mem[to_addr(idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
    idx   <= idx_next;
    total <= total_next;
  end

  assign last = (({1'b0, idx} + 7'd1) == total);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    total_next = total;
    op_pop     = 1'b0;
    mem_we     = 1'b0;
    out_valid  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          mem_we = 1'b1;
          if (op.kind == OP_FLUSH) begin
            idx_next   = '0;
            total_next = op.total;
            state_next = BK_READ;
          end
        end
      end
      BK_READ: state_next = BK_SEND;
      BK_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last) begin
            state_next = BK_IDLE;
          end else begin
            idx_next   = idx + 6'd1;
            state_next = BK_READ;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign frame_byte    = mem_q;
  assign byte_position = idx;
  assign frame_total   = total;
  assign last_byte     = last;

endmodule

// ===== src/sfr_checker.sv =====
// Port-level checks for the serial frame receiver, attached by bind.
// Depends only on the top level's ports.
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic [5:0] byte_position,
  input logic [6:0] frame_total,
  input logic       last_byte,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_index,
  input logic [8:0] cfg_data
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && out_valid && !out_ready) |=>
      (out_valid && $stable(frame_byte) && $stable(byte_position)
       && $stable(frame_total) && $stable(last_byte)))
    else $error("stalled result changed");

  // last marker sits exactly on the final position
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_byte == (({1'b0, byte_position} + 7'd1) == frame_total)))
    else $error("last_byte does not match position and total");

  // frame totals stay within the legal frame sizes
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_total >= 7'd5 && frame_total <= 7'd64))
    else $error("frame_total out of range");

  // a non-final transfer is followed by the next position of the same frame
  a_next_pos: assert property (@(posedge clk) disable iff (rst)
    (!rst && out_valid && out_ready && !last_byte) |=> ##1
      (out_valid && byte_position == ($past(byte_position, 2) + 6'd1)
       && frame_total == $past(frame_total, 2)))
    else $error("frame readout skipped or repeated a position");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the serial frame receiver: drives received bytes, collects frame runs.
// Depends on sfr_pkg (register indexes, reset values, phase_t, FRAME_CAP, FRAME_BUFFER_DEPTH) and the
// serial_frame_receiver RTL; needs nothing else.
module tb import sfr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT = 29;       // chance per cycle that a side idles
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 16;  // queue depth plus pipeline, with margin
  localparam int MAX_REPORTS = 10;

  // One expected transfer on the frame output.
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic [6:0] total;
    logic       last;
  } frame_rec_t;

  // Directed stimulus row: the byte and how many frame bytes it releases.
  typedef struct packed {
    logic [7:0] rx;
    logic [6:0] n_out;
  } dir_row_t;

  // Walked at reset settings (headers 0xAA 0xAF, function below 0xF1, length below 50).
  localparam dir_row_t DIR_ROWS [22] = '{
    '{8'h00, 7'd0},                                 // noise while hunting
    '{8'hAA, 7'd0}, '{8'hAF, 7'd0}, '{8'h00, 7'd0}, // zero length ...
    '{8'h00, 7'd0}, '{8'hAA, 7'd0},                 // ... swallows the next byte, even a header
    '{8'hAA, 7'd0}, '{8'hAF, 7'd0}, '{8'hF0, 7'd0}, // highest function accepted
    '{8'h01, 7'd0}, '{8'hFF, 7'd0}, '{8'h00, 7'd6}, // one payload byte, trailer releases six
    '{8'hAA, 7'd0}, '{8'hAF, 7'd0}, '{8'hF1, 7'd0}, // function at the limit is refused
    '{8'hAA, 7'd0}, '{8'hAA, 7'd0}, '{8'hAF, 7'd0}, // broken header is not rechecked
    '{8'hAA, 7'd0}, '{8'hAF, 7'd0}, '{8'h00, 7'd0},
    '{8'h32, 7'd0}                                  // length at the limit is refused
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic [5:0] byte_position;
  logic [6:0] frame_total;
  logic       last_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [8:0] cfg_data = 9'h000;

  // Shared knobs between the sender and the receiver process.
  bit calm = 1'b0;        // no idling on either side
  bit hold_req = 1'b0;    // ask the receiver for one long hold-off
  bit hold_taken = 1'b0;

  int mismatches = 0;

  // Predictor state: its own copy of the registers and the parser.
  logic [7:0] hdr1_r = FIRST_HEADER_RST;
  logic [7:0] hdr2_r = SECOND_HEADER_RST;
  logic [8:0] func_lim_r = FUNCTION_LIMIT_RST;
  logic [5:0] len_lim_r = LENGTH_LIMIT_RST;
  phase_t     rx_phase = PH_HUNT;
  logic [5:0] pay_left = '0;
  logic [5:0] pay_count = '0;
  logic [7:0] frame_mem [FRAME_BUFFER_DEPTH];

  frame_rec_t frame_bytes_due [$];

  serial_frame_receiver uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .frame_total   (frame_total),
    .last_byte     (last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected %0d, got %0d at %0t ns", what, want, got, $time);
    end
  endtask

  // Advance the parser by one accepted byte; queue the frame run that the trailer releases.
  task automatic parse_rx_byte(input logic [7:0] b, output int released);
    int total;
    frame_rec_t rec;
    released = 0;
    if (rx_phase == PH_HUNT && b == hdr1_r) begin
      rx_phase = PH_HDR1;
      frame_mem[0] = b;
    end else if (rx_phase == PH_HDR1 && b == hdr2_r) begin
      rx_phase = PH_HDR2;
      frame_mem[1] = b;
    end else if (rx_phase == PH_HDR2 && {1'b0, b} < func_lim_r) begin
      rx_phase = PH_FUNC;
      frame_mem[2] = b;
    end else if (rx_phase == PH_FUNC && int'(b) < int'(len_lim_r) &&
                 int'(b) + 5 <= FRAME_CAP) begin
      rx_phase = PH_PAYLOAD;
      frame_mem[3] = b;
      pay_left = b[5:0];
      pay_count = '0;
    end else if (rx_phase == PH_PAYLOAD && pay_left != 0) begin
      pay_left = pay_left - 6'd1;
      if (4 + int'(pay_count) < FRAME_BUFFER_DEPTH) frame_mem[4 + int'(pay_count)] = b;
      pay_count = pay_count + 6'd1;
      if (pay_left == 0) rx_phase = PH_TRAILER;
    end else if (rx_phase == PH_TRAILER) begin
      rx_phase = PH_HUNT;
      if (4 + int'(pay_count) < FRAME_BUFFER_DEPTH) frame_mem[4 + int'(pay_count)] = b;
      total = int'(pay_count) + 5;
      if (total > FRAME_CAP) total = FRAME_CAP;
      for (int i = 0; i < total; i++) begin
        rec.data = (i < FRAME_BUFFER_DEPTH) ? frame_mem[i] : 8'h00;
        rec.pos = 6'(i);
        rec.total = 7'(total);
        rec.last = (i + 1 == total);
        frame_bytes_due.push_back(rec);
      end
      released = total;
    end else begin
      // Anything out of place, including the byte after a zero length: back to hunting.
      rx_phase = PH_HUNT;
    end
  endtask

  // Offer one byte, idling at random first; predict once the transfer happens.
  task automatic push_rx(input logic [7:0] value, output int released);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= value;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(value, released);
  endtask

  // Write one register; cfg_valid stays high between back-to-back writes.
  task automatic write_reg(input logic [7:0] idx, input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIRST_HEADER:   hdr1_r = value[7:0];
      REG_SECOND_HEADER:  hdr2_r = value[7:0];
      REG_FUNCTION_LIMIT: func_lim_r = value;
      REG_LENGTH_LIMIT:   len_lim_r = value[5:0];
      default: ;
    endcase
  endtask

  // Hold the input low until every frame byte is out, then let the queue run dry.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program all four registers, then send mostly well-formed frames with random content.
  task automatic run_phase(input logic [7:0] h1, input logic [7:0] h2,
                           input logic [8:0] flim, input logic [5:0] llim, input int budget);
    int sent;
    int roll;
    int max_len;
    int len;
    int cut;
    int n;
    logic [7:0] plan [$];
    write_reg(REG_FIRST_HEADER, {1'b0, h1});
    write_reg(REG_SECOND_HEADER, {1'b0, h2});
    write_reg(REG_FUNCTION_LIMIT, flim);
    write_reg(REG_LENGTH_LIMIT, {3'b000, llim});
    cfg_valid <= 1'b0;
    sent = 0;
    while (sent < budget) begin
      plan.delete();
      roll = $urandom_range(99);
      if (roll < 12) begin
        // plain line noise
        repeat ($urandom_range(1, 4)) plan.push_back(8'($urandom_range(255)));
      end else begin
        plan.push_back(hdr1_r);
        plan.push_back(hdr2_r);
        plan.push_back(8'($urandom_range((func_lim_r == 0 || func_lim_r > 255) ?
                                         255 : int'(func_lim_r) - 1)));
        max_len = int'(len_lim_r) - 1;
        if (max_len > FRAME_CAP - 5) max_len = FRAME_CAP - 5;
        if (max_len < 0 || $urandom_range(99) < 5) begin
          // refused length: at or above the limit, or a frame that would not fit
          plan.push_back(8'($urandom_range(max_len + 1, 63)));
        end else begin
          if ($urandom_range(99) < 80) len = $urandom_range(0, (max_len < 6) ? max_len : 6);
          else len = $urandom_range(0, max_len);
          plan.push_back(8'(len));
          // payload bytes plus the trailer; a zero length takes one throwaway byte
          repeat (len + 1) plan.push_back(8'($urandom_range(255)));
        end
        if (roll < 22 && plan.size() > 1) begin
          // break the frame somewhere and follow with a random byte
          cut = $urandom_range(1, plan.size() - 1);
          while (plan.size() > cut) void'(plan.pop_back());
          plan.push_back(8'($urandom_range(255)));
        end
      end
      foreach (plan[i]) push_rx(plan[i], n);
      sent += plan.size();
    end
    drain_and_settle();
  endtask

  // Receiver: random stalls, one long hold-off on request, none while calm.
  initial begin
    int hold_cnt;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Check each output transfer against the oldest expected frame byte.
  always @(posedge clk) begin
    frame_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        note_mismatch("frame byte with nothing pending", -1, frame_byte);
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_byte !== want.data) note_mismatch("frame_byte", want.data, frame_byte);
        if (byte_position !== want.pos) note_mismatch("byte_position", want.pos, byte_position);
        if (frame_total !== want.total) note_mismatch("frame_total", want.total, frame_total);
        if (last_byte !== want.last) note_mismatch("last_byte", want.last, last_byte);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases across register settings.
  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      push_rx(DIR_ROWS[i].rx, n);
      if (n != int'(DIR_ROWS[i].n_out)) begin
        note_mismatch("frame bytes released by directed byte", DIR_ROWS[i].n_out, n);
      end
    end
    drain_and_settle();

    // Reset values, with the long receiver hold-off so the input stalls.
    hold_req = 1'b1;
    run_phase(8'hAA, 8'hAF, 9'd241, 6'd50, 60);
    // Extremes: every function accepted, longest lengths, no idling anywhere.
    calm = 1'b1;
    run_phase(8'h00, 8'hFF, 9'd256, 6'd59, 60);
    calm = 1'b0;
    // No function accepted; length limit of one.
    run_phase(8'hFF, 8'h00, 9'd0, 6'd1, 20);
    // Length limit of zero refuses every length.
    run_phase(8'h5A, 8'hA5, 9'd128, 6'd0, 20);
    // Limit above the frame cap: the largest lengths do not fit and are refused.
    run_phase(8'h3C, 8'hC3, 9'd255, 6'd63, 40);
    // Random in-range setting.
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 9'($urandom_range(256)),
              6'($urandom_range(1, 59)), 60);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
